// ----- src/eth_arp_pkg.sv -----
// Shared types and constants of the Ethernet address filter with ARP responder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package eth_arp_pkg;

    // Ethernet and ARP field values
    localparam logic [15:0] ETH_BCAST     = 16'hffff;
    localparam logic [15:0] ETYPE_ARP     = 16'h0806;
    localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
    localparam logic [15:0] ARP_PTYPE_IP4 = 16'h0800;
    localparam logic [15:0] ARP_LENS      = 16'h0604;
    localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;

    // Frame word positions inside the capture buffer
    localparam int WORD_ETYPE  = 6;
    localparam int WORD_OPER   = 10;
    localparam int WORD_SENDER = 11;
    localparam int REQ_WORDS   = 5;
    localparam int VIEW_WORDS  = 16;

    // Result codes
    localparam logic       KIND_VERDICT   = 1'b0;
    localparam logic       KIND_TX        = 1'b1;
    localparam logic [1:0] VERDICT_DROP   = 2'd0;
    localparam logic [1:0] VERDICT_ARP    = 2'd1;
    localparam logic [1:0] VERDICT_ACCEPT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAC_HIGH   = 3'd0;
    localparam logic [2:0] CFG_MAC_MIDDLE = 3'd1;
    localparam logic [2:0] CFG_MAC_LOW    = 3'd2;
    localparam logic [2:0] CFG_IP_HIGH    = 3'd3;
    localparam logic [2:0] CFG_IP_LOW     = 3'd4;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0] mac_high;
        logic [15:0] mac_middle;
        logic [15:0] mac_low;
        logic [15:0] ip_high;
        logic [15:0] ip_low;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_DROP,
        JOB_ARP,
        JOB_REPLY,
        JOB_ACCEPT
    } job_kind_t;

    // One classified frame; req holds request words 11 to 15
    typedef struct packed {
        job_kind_t                        kind;
        logic [15:0]                      bytes;
        logic [REQ_WORDS-1:0][15:0]       req;
    } job_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] value;
        logic [1:0]  verdict;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ----- src/eth_mac_filter_arp_responder.sv -----
// Top level: configuration registers, frame classifier, job queue and result sequencer.
// Depends on eth_arp_pkg, eth_arp_front, eth_arp_queue and eth_arp_back.
//
//  channel  | signals                                  | word
//  ---------+------------------------------------------+---------------------------------
//  in       | in_valid, in_ready, rx_word              | byte count, then frame words
//  out      | out_valid, out_ready, kind/value/verdict | verdict or transmit word
//           | /last                                    |
//  cfg      | cfg_we, cfg_index, cfg_data              | local MAC and IP, indexes 0..4
//
// One input word is taken every cycle while the job queue has room; the word
// that ends a frame pushes one job. The sequencer emits one result per cycle while
// out_ready holds: one for a plain verdict, (REPLY_BYTES + 1)/2 + 2 for an ARP request.
// The queue fills only during a reply burst or a stalled output, and then
// input stalls. Reset clears all control state; no clearing pass is needed.
`default_nettype none

module eth_mac_filter_arp_responder #(
    parameter int REPLY_BYTES   = 64,
    parameter int CAPTURE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] rx_word,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        kind,
    output logic [15:0] value,
    output logic [1:0]  verdict,
    output logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import eth_arp_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    q_push, q_full, q_pop, q_valid;
    job_t    push_job, head_job;
    result_t result;

    // Decode configuration writes; ignore unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAC_HIGH:   cfg_next.mac_high   = cfg_data;
                CFG_MAC_MIDDLE: cfg_next.mac_middle = cfg_data;
                CFG_MAC_LOW:    cfg_next.mac_low    = cfg_data;
                CFG_IP_HIGH:    cfg_next.ip_high    = cfg_data;
                CFG_IP_LOW:     cfg_next.ip_low     = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    eth_arp_front #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_word  (rx_word),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    eth_arp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    eth_arp_back #(
        .REPLY_BYTES (REPLY_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .result     (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    assign kind    = result.kind;
    assign value   = result.value;
    assign verdict = result.verdict;
    assign last    = result.last;

endmodule

`default_nettype wire

// ----- src/eth_arp_front.sv -----
// Front end: accepts stream words, captures frame words and classifies each frame.
// Depends on eth_arp_pkg; pushes one job per finished frame into eth_arp_queue.
`default_nettype none

module eth_arp_front #(
    parameter int CAPTURE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        rx_word,
    input  logic               in_valid,
    output logic               in_ready,
    input  eth_arp_pkg::cfg_t  cfg,
    input  logic               q_full,
    output logic               q_push,
    output eth_arp_pkg::job_t  q_job
);
    import eth_arp_pkg::*;

    localparam int PW = $clog2(CAPTURE_DEPTH + 1);
    localparam int IW = $clog2(CAPTURE_DEPTH);

    logic              awaiting_reg, awaiting_next;
    logic [15:0]       bytes_reg, bytes_next;
    logic [14:0]       left_reg, left_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [15:0]       cap_reg [CAPTURE_DEPTH];

    logic              accept;
    logic              frame_end;
    logic [16:0]       count_sum;
    logic [15:0]       count_words;
    logic [15:0]       view [VIEW_WORDS];
    logic              mac_ok;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Words due after the first one: ceil(count / 2) - 1
    assign count_sum   = {1'b0, rx_word} + 17'd1;
    assign count_words = count_sum[16:1];

    // Control state of the frame parser
    always_comb
    begin
        awaiting_next = awaiting_reg;
        bytes_next    = bytes_reg;
        left_next     = left_reg;
        pos_next      = pos_reg;
        frame_end     = 1'b0;
        if (accept)
        begin
            if (awaiting_reg)
            begin
                bytes_next = rx_word;
                pos_next   = '0;
                if (rx_word == 16'd0)
                begin
                    left_next = '0;
                end
                else
                begin
                    left_next     = 15'(count_words - 16'd1);
                    awaiting_next = 1'b0;
                end
            end
            else
            begin
                if (pos_reg != PW'(CAPTURE_DEPTH))
                    pos_next = pos_reg + PW'(1);
                if (left_reg != 15'd0)
                begin
                    left_next = left_reg - 15'd1;
                end
                else
                begin
                    awaiting_next = 1'b1;
                    frame_end     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            left_reg     <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            left_reg     <= left_next;
            pos_reg      <= pos_next;
        end
    end

    // Byte count and capture buffer; clear the buffer on each count word
    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        if (accept && awaiting_reg)
        begin
            for (int i = 0; i < CAPTURE_DEPTH; i++)
                cap_reg[i] <= '0;
        end
        else if (accept && (pos_reg < PW'(CAPTURE_DEPTH)))
        begin
            cap_reg[pos_reg[IW-1:0]] <= rx_word;
        end
    end

    // Buffer as it stands with the incoming word written in
    always_comb
    begin
        for (int i = 0; i < VIEW_WORDS; i++)
            view[i] = (pos_reg == PW'(i)) ? rx_word : cap_reg[i];
    end

    assign mac_ok = (view[0] == cfg.mac_high   || view[0] == ETH_BCAST) &&
                    (view[1] == cfg.mac_middle || view[1] == ETH_BCAST) &&
                    (view[2] == cfg.mac_low    || view[2] == ETH_BCAST);

    // Classify the frame on its final word, or drop a zero-length frame at once
    always_comb
    begin
        q_push      = 1'b0;
        q_job.kind  = JOB_DROP;
        q_job.bytes = bytes_reg;
        for (int i = 0; i < REQ_WORDS; i++)
            q_job.req[i] = view[WORD_SENDER + i];
        if (accept && awaiting_reg && rx_word == 16'd0)
        begin
            q_push = 1'b1;
        end
        else if (frame_end)
        begin
            q_push = 1'b1;
            if (!mac_ok)
                q_job.kind = JOB_DROP;
            else if (view[WORD_ETYPE] == ETYPE_ARP)
                q_job.kind = (view[WORD_OPER] == ARP_OP_REQ) ? JOB_REPLY : JOB_ARP;
            else
                q_job.kind = JOB_ACCEPT;
        end
    end

endmodule

`default_nettype wire

// ----- src/eth_arp_queue.sv -----
// Short job queue that decouples the frame classifier from the result sequencer.
// Depends on eth_arp_pkg for the job type and queue depth.
`default_nettype none

module eth_arp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  eth_arp_pkg::job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output eth_arp_pkg::job_t head_job
);
    import eth_arp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CW'(QUEUE_DEPTH))
        else $error("job queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("job queue popped while empty");

endmodule

`default_nettype wire

// ----- src/eth_arp_back.sv -----
// Back end: turns queued jobs into result words, including the ARP reply frame.
// Depends on eth_arp_pkg; reads jobs from eth_arp_queue and drives the output register.
`default_nettype none

module eth_arp_back #(
    parameter int REPLY_BYTES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eth_arp_pkg::cfg_t    cfg,
    input  logic                 head_valid,
    input  eth_arp_pkg::job_t    head_job,
    output logic                 pop,
    output eth_arp_pkg::result_t result,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import eth_arp_pkg::*;

    localparam int REPLY_WORDS = (REPLY_BYTES + 1) / 2;
    localparam int SW          = $clog2(REPLY_WORDS + 2);

    logic [SW-1:0] seq_reg, seq_next;
    result_t       res_reg, res_next;
    logic          valid_reg, valid_next;
    logic          load;
    logic [SW-1:0] word_idx;

    // Word i of the reply frame
    function automatic logic [15:0] reply_word(input logic [SW-1:0] idx, input cfg_t c,
                                               input job_t j);
        logic [15:0] w;
        case (idx)
            SW'(0), SW'(16): w = j.req[0];
            SW'(1), SW'(17): w = j.req[1];
            SW'(2), SW'(18): w = j.req[2];
            SW'(19):         w = j.req[3];
            SW'(20):         w = j.req[4];
            SW'(3), SW'(11): w = c.mac_high;
            SW'(4), SW'(12): w = c.mac_middle;
            SW'(5), SW'(13): w = c.mac_low;
            SW'(6):          w = ETYPE_ARP;
            SW'(7):          w = ARP_HTYPE_ETH;
            SW'(8):          w = ARP_PTYPE_IP4;
            SW'(9):          w = ARP_LENS;
            SW'(10):         w = ARP_OP_REPLY;
            SW'(14):         w = c.ip_high;
            SW'(15):         w = c.ip_low;
            default:         w = '0;
        endcase
        return w;
    endfunction

    assign load     = !valid_reg || out_ready;
    assign word_idx = seq_reg - SW'(1);

    // Build the next result word from the queue head
    always_comb
    begin
        seq_next   = seq_reg;
        res_next   = res_reg;
        valid_next = valid_reg && !out_ready;
        pop        = 1'b0;
        if (load && head_valid)
        begin
            valid_next       = 1'b1;
            res_next.kind    = KIND_VERDICT;
            res_next.value   = '0;
            res_next.verdict = VERDICT_DROP;
            res_next.last    = 1'b1;
            case (head_job.kind)
                JOB_ARP:
                begin
                    res_next.verdict = VERDICT_ARP;
                    pop              = 1'b1;
                end
                JOB_ACCEPT:
                begin
                    res_next.value   = head_job.bytes;
                    res_next.verdict = VERDICT_ACCEPT;
                    pop              = 1'b1;
                end
                JOB_REPLY:
                begin
                    if (seq_reg == SW'(REPLY_WORDS + 1))
                    begin
                        res_next.verdict = VERDICT_ARP;
                        pop              = 1'b1;
                        seq_next         = '0;
                    end
                    else
                    begin
                        res_next.kind  = KIND_TX;
                        res_next.last  = 1'b0;
                        res_next.value = (seq_reg == '0) ? 16'(REPLY_BYTES)
                                         : reply_word(word_idx, cfg, head_job);
                        seq_next       = seq_reg + SW'(1);
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg   <= seq_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result    = res_reg;
    assign out_valid = valid_reg;

    a_seq_on_reply: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != '0 |-> head_valid && head_job.kind == JOB_REPLY)
        else $error("reply sequencer running without a reply job at the queue head");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg && res_reg.last)
        else $error("job retired without a final result");

endmodule

`default_nettype wire
